// ===== design/whp_pkg.sv =====
// whp_pkg: shared types and constants of the wav header parser
// no dependencies; used by whp_div and wav_header_parser_unit
package whp_pkg;

   localparam int CLK_W = 27;
   localparam logic [CLK_W-1:0] CLOCK_HZ_RESET = 27'd32000000;

   localparam int MIN_DATA_BYTES = 1024;
   localparam int MAX_FMT_BYTES = 100;
   localparam logic [31:0] MIN_FMT_BYTES = 32'd16;

   localparam logic [31:0] TAG_WAVE = 32'h45564157;
   localparam logic [31:0] TAG_FMT  = 32'h20746D66;
   localparam logic [31:0] TAG_DATA = 32'h61746164;
   localparam logic [31:0] TAG_DISP = 32'h50534944;
   localparam logic [31:0] TAG_LIST = 32'h5453494C;
   localparam logic [31:0] TAG_FACT = 32'h74636166;

   localparam logic [7:0] PCM_CODE = 8'd1;
   localparam logic [7:0] CHAN_MONO = 8'd1;
   localparam logic [7:0] CHAN_STEREO = 8'd2;
   localparam logic [7:0] BITS_8 = 8'd8;
   localparam logic [7:0] BITS_16 = 8'd16;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HDR,
      PH_CHDR,
      PH_FMT,
      PH_SKIP,
      PH_DONE,
      PH_DIV
   } phase_type;

endpackage

// ===== design/wav_header_parser_unit.sv =====
// wav header parser: one file byte per item, at most one verdict per file
// depends on whp_pkg and whp_div
// throughput: one byte per cycle while no verdict waits on rsp_ready; the last byte of a
// fmt chunk is followed by a stall while the 27-step divider forms clock_hz / sample rate
// latency: a verdict is registered and shown the cycle after its deciding byte
// reset: synchronous, parser idle until a start-of-file byte, clock_hz = 32000000
module wav_header_parser_unit #(
   parameter int MIN_DATA_BYTES = whp_pkg::MIN_DATA_BYTES,
   parameter int MAX_FMT_BYTES = whp_pkg::MAX_FMT_BYTES
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_data_byte,
   input  logic                      req_start_of_file,
   input  logic                      req_end_of_file,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_status,
   output logic [1:0]                rsp_channels,
   output logic [4:0]                rsp_bits_per_sample,
   output logic [15:0]               rsp_timer_period,
   output logic [31:0]               rsp_data_bytes,
   input  logic                      csr_wr_en,
   input  logic [whp_pkg::CLK_W-1:0] csr_wr_data
);

   localparam int CNT_W = $clog2(MAX_FMT_BYTES + 1);

   whp_pkg::phase_type        phase_ff, phase_in, cur_phase;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [31:0]               word_ff, word_in;
   logic [31:0]               len_ff, len_in;
   logic [1:0]                chan_ff, chan_in;
   logic [4:0]                bits_ff, bits_in;
   logic [31:0]               rate_ff, rate_in;
   logic [15:0]               period_ff, period_in;
   logic                      bad_ff, bad_in;
   logic [whp_pkg::CLK_W-1:0] clock_hz_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      status_ff;
   logic [1:0]                rsp_chan_ff;
   logic [4:0]                rsp_bits_ff;
   logic [15:0]               rsp_period_ff;
   logic [31:0]               rsp_size_ff;
   logic                      accept;
   logic                      emit;
   logic                      emit_ok;
   logic [32:0]               len_even;
   logic                      bad;
   logic [15:0]               div_quot;
   logic                      div_start;
   logic                      div_done;

   assign req_ready = (phase_ff != whp_pkg::PH_DIV) && (!rsp_valid_ff || rsp_ready);
   assign accept = req_valid && req_ready;

   always_comb begin
      phase_in = phase_ff;
      cnt_in = cnt_ff;
      word_in = word_ff;
      len_in = len_ff;
      chan_in = chan_ff;
      bits_in = bits_ff;
      rate_in = rate_ff;
      period_in = period_ff;
      bad_in = bad_ff;
      emit = 1'b0;
      emit_ok = 1'b0;
      div_start = 1'b0;
      len_even = '0;
      bad = 1'b0;
      cur_phase = phase_ff;
      if (accept && req_start_of_file) begin
         cur_phase = whp_pkg::PH_HDR;
         phase_in = whp_pkg::PH_HDR;
         cnt_in = '0;
         word_in = '0;
         len_in = '0;
         chan_in = '0;
         bits_in = '0;
         rate_in = '0;
         period_in = '0;
         bad_in = 1'b0;
      end
      if (phase_ff == whp_pkg::PH_DIV) begin
         if (div_done) begin
            period_in = div_quot;
            cnt_in = '0;
            phase_in = whp_pkg::PH_CHDR;
         end
      end else if (accept && cur_phase != whp_pkg::PH_IDLE
                   && cur_phase != whp_pkg::PH_DONE) begin
         if (req_end_of_file) begin
            emit = 1'b1;
         end else begin
            unique case (cur_phase)
               whp_pkg::PH_HDR: begin
                  word_in = {req_data_byte, word_in[31:8]};
                  cnt_in = cnt_in + 1'b1;
                  if (cnt_in == CNT_W'(12)) begin
                     if (word_in != whp_pkg::TAG_WAVE) begin
                        emit = 1'b1;
                     end else begin
                        cnt_in = '0;
                        phase_in = whp_pkg::PH_CHDR;
                     end
                  end
               end
               whp_pkg::PH_CHDR: begin
                  if (cnt_in < CNT_W'(4)) begin
                     word_in = {req_data_byte, word_in[31:8]};
                  end else begin
                     len_in = {req_data_byte, len_in[31:8]};
                  end
                  cnt_in = cnt_in + 1'b1;
                  if (cnt_in == CNT_W'(8)) begin
                     cnt_in = '0;
                     len_even = {1'b0, len_in} + {32'd0, len_in[0]};
                     priority if (word_in == whp_pkg::TAG_FMT) begin
                        len_in = len_even[31:0];
                        if (len_in > 32'(MAX_FMT_BYTES) || len_in < whp_pkg::MIN_FMT_BYTES) begin
                           emit = 1'b1;
                        end else begin
                           bad_in = 1'b0;
                           phase_in = whp_pkg::PH_FMT;
                        end
                     end else if (word_in == whp_pkg::TAG_DATA) begin
                        emit = 1'b1;
                        emit_ok = len_in >= 32'(MIN_DATA_BYTES);
                     end else if (word_in == whp_pkg::TAG_DISP || word_in == whp_pkg::TAG_LIST
                                  || word_in == whp_pkg::TAG_FACT) begin
                        len_in = len_even[31:0];
                        phase_in = (len_in == '0) ? whp_pkg::PH_CHDR : whp_pkg::PH_SKIP;
                     end else begin
                        emit = 1'b1;
                     end
                  end
               end
               whp_pkg::PH_FMT: begin
                  bad = bad_in;
                  if (cnt_in == CNT_W'(0) && req_data_byte != whp_pkg::PCM_CODE) begin
                     bad = 1'b1;
                  end
                  if (cnt_in == CNT_W'(2)) begin
                     if (req_data_byte == whp_pkg::CHAN_MONO
                         || req_data_byte == whp_pkg::CHAN_STEREO) begin
                        chan_in = req_data_byte[1:0];
                     end else begin
                        bad = 1'b1;
                     end
                  end
                  if (cnt_in == CNT_W'(14)) begin
                     if (req_data_byte == whp_pkg::BITS_8 || req_data_byte == whp_pkg::BITS_16) begin
                        bits_in = req_data_byte[4:0];
                     end else begin
                        bad = 1'b1;
                     end
                  end
                  if (cnt_in >= CNT_W'(4) && cnt_in <= CNT_W'(7)) begin
                     rate_in = {req_data_byte, rate_in[31:8]};
                  end
                  bad_in = bad;
                  cnt_in = cnt_in + 1'b1;
                  if (cnt_in >= len_ff[CNT_W-1:0]) begin
                     if (bad || rate_in == '0) begin
                        emit = 1'b1;
                     end else begin
                        div_start = 1'b1;
                        phase_in = whp_pkg::PH_DIV;
                     end
                  end
               end
               whp_pkg::PH_SKIP: begin
                  len_in = len_in - 1'b1;
                  if (len_in == '0) begin
                     cnt_in = '0;
                     phase_in = whp_pkg::PH_CHDR;
                  end
               end
               default: begin
                  phase_in = whp_pkg::PH_IDLE;
               end
            endcase
         end
      end
      if (emit) begin
         phase_in = whp_pkg::PH_DONE;
      end
      rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   whp_div #(
      .CLK_W(whp_pkg::CLK_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (clock_hz_ff),
      .divisor  (rate_in),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= whp_pkg::PH_IDLE;
         cnt_ff <= '0;
         word_ff <= '0;
         len_ff <= '0;
         chan_ff <= '0;
         bits_ff <= '0;
         rate_ff <= '0;
         period_ff <= '0;
         bad_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff <= cnt_in;
         word_ff <= word_in;
         len_ff <= len_in;
         chan_ff <= chan_in;
         bits_ff <= bits_in;
         rate_ff <= rate_in;
         period_ff <= period_in;
         bad_ff <= bad_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff <= whp_pkg::CLOCK_HZ_RESET;
      end else if (csr_wr_en) begin
         clock_hz_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         status_ff <= !emit_ok;
         rsp_chan_ff <= emit_ok ? chan_in : '0;
         rsp_bits_ff <= emit_ok ? bits_in : '0;
         rsp_period_ff <= emit_ok ? period_in : '0;
         rsp_size_ff <= emit_ok ? len_in : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_channels = rsp_chan_ff;
   assign rsp_bits_per_sample = rsp_bits_ff;
   assign rsp_timer_period = rsp_period_ff;
   assign rsp_data_bytes = rsp_size_ff;

`ifndef NO_ASSERTIONS
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> phase_ff == whp_pkg::PH_DIV)
      else $error("divider finished outside the divide phase");

   a_start_enters_div: assert property (@(posedge clock) disable iff (reset)
      div_start |=> phase_ff == whp_pkg::PH_DIV && !req_ready)
      else $error("divide started but parser still takes bytes");

   a_bad_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_data_bytes == '0 && rsp_channels == '0
                                  && rsp_timer_period == '0)
      else $error("invalid verdict carries nonzero fields");

   a_ok_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_status |-> rsp_data_bytes >= 32'(MIN_DATA_BYTES))
      else $error("playable verdict with short data chunk");

   a_emit_done: assert property (@(posedge clock) disable iff (reset)
      emit |=> phase_ff == whp_pkg::PH_DONE && rsp_valid)
      else $error("verdict given without closing the parse");
`endif

endmodule

// ===== design/whp_div.sv =====
// whp_div: restoring divider, one quotient bit per cycle
// depends on whp_pkg; used by wav_header_parser_unit for clock over sample rate
module whp_div #(
   parameter int CLK_W = whp_pkg::CLK_W
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [CLK_W-1:0]     dividend,
   input  logic [31:0]          divisor,
   output logic                 done,
   output logic [15:0]          quotient
);

   localparam int STEP_W = $clog2(CLK_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [CLK_W-1:0]    quot_ff, quot_in;
   logic [31:0]         rem_ff, rem_in;
   logic [31:0]         dvsr_ff, dvsr_in;
   logic [32:0]         shifted;
   logic [32:0]         diff;
   logic                fits;

   always_comb begin
      shifted = {rem_ff, quot_ff[CLK_W-1]};
      diff = shifted - {1'b0, dvsr_ff};
      fits = shifted >= {1'b0, dvsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quot_in = quot_ff;
      rem_in = rem_ff;
      dvsr_in = dvsr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quot_in = dividend;
         rem_in = '0;
         dvsr_in = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[31:0] : shifted[31:0];
         quot_in = {quot_ff[CLK_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(CLK_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      dvsr_ff <= dvsr_in;
   end

   assign done = done_ff;
   assign quotient = quot_ff[15:0];

endmodule
